### design/wpse_pkg.sv
// Shared types and constants of the wind and pitot scale estimator.
// Holds the CORDIC arctangent table (built at elaboration) and the result record.
// No dependencies.
package wpse_pkg;

    // Step counts of the shared serial units.
    localparam int MUL_STEPS    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 44;

    // Fixed multiplier constants: kt to m/s (Q0.20), CORDIC gain (Q0.30),
    // and CORDIC gain times m/s to kt (Q.20).
    localparam logic [29:0] KT_TO_MPS_Q20      = 30'd539434;
    localparam logic [29:0] GAIN_Q30           = 30'd652032874;
    localparam logic [29:0] GAIN_MPS_TO_KT_Q20 = 30'd1237745;
    localparam logic [63:0] INV_TWO_PI_Q32     = 64'd683565276;

    // Binary angle constants in the 34-bit angle accumulator.
    localparam logic signed [33:0] Z_QUARTER  = 34'sh0_4000_0000;
    localparam logic signed [33:0] Z_NQUARTER = -34'sh0_4000_0000;
    localparam logic signed [33:0] Z_HALF     = 34'sh0_8000_0000;

    // Reset values of the registers and the filter state.
    localparam logic [15:0] MIN_AIRSPEED_RST  = 16'd3840;
    localparam logic [23:0] WIND_ALPHA_RST    = 24'd3355;
    localparam logic [23:0] SCALE_ALPHA_RST   = 24'd8389;
    localparam logic [15:0] SCALE_FLOOR_RST   = 16'd12288;
    localparam logic [15:0] SCALE_CEILING_RST = 16'd20480;
    localparam logic [39:0] SCALE_ONE         = 40'h40_0000_0000;
    localparam logic [15:0] RAW_SCALE_ONE     = 16'd16384;
    localparam logic [15:0] ANGLE_EAST        = 16'd16384;
    localparam logic [15:0] ONE_KNOT          = 16'd256;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_AIRSPEED  = 3'd0;
    localparam logic [2:0] CFG_WIND_ALPHA    = 3'd1;
    localparam logic [2:0] CFG_SCALE_ALPHA   = 3'd2;
    localparam logic [2:0] CFG_SCALE_FLOOR   = 3'd3;
    localparam logic [2:0] CFG_SCALE_CEILING = 3'd4;

    typedef logic [31:0] t_atan_tab [CORDIC_STEPS];

    // One result record as it leaves the block.
    typedef struct packed {
        logic [15:0]        wind_speed;
        logic [15:0]        wind_direction;
        logic signed [15:0] wind_east;
        logic signed [15:0] wind_north;
        logic [15:0]        true_air_speed;
        logic [15:0]        true_air_direction;
        logic signed [15:0] true_air_east;
        logic signed [15:0] true_air_north;
        logic [15:0]        pitot_factor;
    } t_result;

    // Shift and subtract long division, used only while building the table.
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = num;
        for (int b = 0; b < 64; b++) begin
            rem = {rem[63:0], quo[63]};
            quo = {quo[62:0], 1'b0};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Arctangent of 2^-i as a 32-bit binary angle: the series is summed in
    // Q60, rounded to Q32 radians and scaled by 1/(2 pi).
    function automatic t_atan_tab build_atan_tab();
        t_atan_tab         tab;
        logic signed [63:0] s;
        logic [63:0]       term;
        logic [63:0]       q;
        int                e;
        tab[0] = 32'h2000_0000;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            s = '0;
            for (int k = 0; k < 64; k++) begin
                e = 60 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = long_div(64'd1 << e, 64'(2 * k + 1));
                    s    = k[0] ? s - $signed(term) : s + $signed(term);
                end
            end
            q = ((((64'(s) + (64'd1 << 27)) >> 28) * INV_TWO_PI_Q32) + (64'd1 << 31)) >> 32;
            tab[i] = q[31:0];
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan_tab();

endpackage

### design/wind_and_pitot_scale_estimator_top.sv
// Wind and pitot scale estimator: one sequencer driving a bit-serial multiplier,
// an iterative CORDIC and a restoring divider. Depends on wpse_pkg.
// A request runs through eight serial products, three 30-iteration CORDIC passes
// and a restoring divide; a zero vector skips its vectoring pass and product, and
// an airspeed of 1 kt or less skips the divide.
// A new request is taken only after the last result is loaded into the output
// register, which waits while a result is held; a slow sample is taken and dropped.
// Synchronous active-low reset restores the default registers and the filter state.
module wind_and_pitot_scale_estimator_top import wpse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_indicated_airspeed,
    input  logic [15:0]        i_heading_angle,
    input  logic signed [15:0] i_ground_vel_east,
    input  logic signed [15:0] i_ground_vel_north,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_wind_speed,
    output logic [15:0]        o_wind_direction,
    output logic signed [15:0] o_wind_east,
    output logic signed [15:0] o_wind_north,
    output logic [15:0]        o_true_air_speed,
    output logic [15:0]        o_true_air_direction,
    output logic signed [15:0] o_true_air_east,
    output logic signed [15:0] o_true_air_north,
    output logic [15:0]        o_pitot_factor
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CORD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_POST = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // Job whose completion is handled in ST_POST.
    localparam logic [3:0] PH_U0  = 4'd0;
    localparam logic [3:0] PH_U   = 4'd1;
    localparam logic [3:0] PH_X0  = 4'd2;
    localparam logic [3:0] PH_ROT = 4'd3;
    localparam logic [3:0] PH_WE  = 4'd4;
    localparam logic [3:0] PH_WN  = 4'd5;
    localparam logic [3:0] PH_VWS = 4'd6;
    localparam logic [3:0] PH_VW  = 4'd7;
    localparam logic [3:0] PH_KW  = 4'd8;
    localparam logic [3:0] PH_VTS = 4'd9;
    localparam logic [3:0] PH_VT  = 4'd10;
    localparam logic [3:0] PH_KT  = 4'd11;
    localparam logic [3:0] PH_DVS = 4'd12;
    localparam logic [3:0] PH_DV  = 4'd13;
    localparam logic [3:0] PH_SC  = 4'd14;

    logic [2:0]  r_state;
    logic [3:0]  r_phase;
    logic [5:0]  r_cnt;

    // Configuration registers.
    logic [15:0] r_min_airspeed;
    logic [23:0] r_wind_alpha;
    logic [23:0] r_scale_alpha;
    logic [15:0] r_scale_floor;
    logic [15:0] r_scale_ceiling;

    // Filter state.
    logic signed [39:0] r_fwe;
    logic signed [39:0] r_fwn;
    logic [39:0]        r_fs;

    // Latched request.
    logic [15:0]        r_ias;
    logic [15:0]        r_head;
    logic signed [15:0] r_gve;
    logic signed [15:0] r_gvn;

    // Serial multiplier.
    logic signed [47:0] r_ma;
    logic [29:0]        r_mc;
    logic signed [48:0] r_macc;
    logic [29:0]        r_mlo;

    // CORDIC unit; r_cmode high means vectoring.
    logic signed [44:0] r_cx;
    logic signed [44:0] r_cy;
    logic signed [33:0] r_cz;
    logic               r_cmode;

    // Divider.
    logic [43:0] r_dq;
    logic [25:0] r_rem;

    // Intermediate results.
    logic signed [44:0] r_un;
    logic [15:0]        r_wspd;
    logic [15:0]        r_wdir;
    logic [15:0]        r_tspd;
    logic [15:0]        r_tdir;
    logic [43:0]        r_tkt;

    logic    r_out_valid;
    t_result r_res;

    logic               w_in_acc;
    logic               w_out_free;
    logic signed [48:0] w_madd;
    logic signed [78:0] w_prod;
    logic signed [44:0] w_dx;
    logic signed [44:0] w_dy;
    logic signed [33:0] w_tab;
    logic               w_cplus;
    logic signed [33:0] w_zh;
    logic signed [33:0] w_zf;
    logic               w_flip;
    logic signed [44:0] w_x0;
    logic signed [47:0] w_ve48;
    logic signed [47:0] w_vn48;
    logic signed [47:0] w_fw_old;
    logic signed [47:0] w_wsum;
    logic signed [39:0] w_wsat;
    logic signed [40:0] w_te;
    logic signed [40:0] w_tn;
    logic signed [44:0] w_vx_in;
    logic signed [44:0] w_vy_in;
    logic               w_vzero;
    logic [31:0]        w_zr;
    logic signed [44:0] w_k;
    logic [43:0]        w_kpos;
    logic [15:0]        w_spd;
    logic [26:0]        w_dsh;
    logic [27:0]        w_ddiff;
    logic               w_dge;
    logic [15:0]        w_raw;
    logic [15:0]        w_rawf;
    logic signed [47:0] w_sd;
    logic signed [41:0] w_fsn;
    logic [39:0]        w_fssat;
    logic [15:0]        w_te_sat;
    logic [15:0]        w_tn_sat;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_wind_speed         = r_res.wind_speed;
    assign o_wind_direction     = r_res.wind_direction;
    assign o_wind_east          = r_res.wind_east;
    assign o_wind_north         = r_res.wind_north;
    assign o_true_air_speed     = r_res.true_air_speed;
    assign o_true_air_direction = r_res.true_air_direction;
    assign o_true_air_east      = r_res.true_air_east;
    assign o_true_air_north     = r_res.true_air_north;
    assign o_pitot_factor       = r_res.pitot_factor;

    // Multiplier step: add the operand when the current multiplier bit is set,
    // then shift the product one place right into the low word.
    assign w_madd = r_macc + (r_mc[0] ? {r_ma[47], r_ma} : 49'sd0);
    assign w_prod = {r_macc, r_mlo};

    // CORDIC micro-rotation terms.
    assign w_dx    = r_cy >>> r_cnt[4:0];
    assign w_dy    = r_cx >>> r_cnt[4:0];
    assign w_tab   = $signed({2'b00, ATAN_TAB[r_cnt[4:0]]});
    assign w_cplus = r_cmode ? r_cy[44] : !r_cz[33];

    // Fold the heading into the right half plane for rotation.
    assign w_zh = {{2{r_head[15]}}, r_head, 16'h0000};
    always_comb begin
        w_zf   = w_zh;
        w_flip = 1'b0;
        if (w_zh > Z_QUARTER) begin
            w_zf   = w_zh - Z_HALF;
            w_flip = 1'b1;
        end else if (w_zh < Z_NQUARTER) begin
            w_zf   = w_zh + Z_HALF;
            w_flip = 1'b1;
        end
    end
    assign w_x0 = w_prod[74:30];

    // Wind filter update with saturation to the 40-bit state range.
    assign w_ve48   = {{8{r_gve[15]}}, r_gve, 24'h000000};
    assign w_vn48   = {{8{r_gvn[15]}}, r_gvn, 24'h000000};
    assign w_fw_old = (r_phase == PH_WE) ? {{8{r_fwe[39]}}, r_fwe} : {{8{r_fwn[39]}}, r_fwn};
    assign w_wsum   = w_fw_old + w_prod[71:24];
    always_comb begin
        if (!w_wsum[47] && (|w_wsum[46:39])) begin
            w_wsat = {1'b0, {39{1'b1}}};
        end else if (w_wsum[47] && !(&w_wsum[46:39])) begin
            w_wsat = {1'b1, {39{1'b0}}};
        end else begin
            w_wsat = w_wsum[39:0];
        end
    end

    // True air vector and the operands of a vectoring pass.
    assign w_te    = {r_fwe[39], r_fwe} + {r_gve[15], r_gve, 24'h000000};
    assign w_tn    = {r_fwn[39], r_fwn} + {r_gvn[15], r_gvn, 24'h000000};
    assign w_vx_in = (r_phase == PH_VWS) ? {{5{r_fwn[39]}}, r_fwn} : {{4{w_tn[40]}}, w_tn};
    assign w_vy_in = (r_phase == PH_VWS) ? {{5{r_fwe[39]}}, r_fwe} : {{4{w_te[40]}}, w_te};
    assign w_vzero = (w_vx_in == 45'sd0) && (w_vy_in == 45'sd0);

    // Angle rounded to 16 bits, speed in knots clamped and saturated.
    assign w_zr   = r_cz[31:0] + 32'd32768;
    assign w_k    = w_prod[64:20];
    assign w_kpos = w_k[44] ? 44'd0 : w_k[43:0];
    assign w_spd  = (|w_kpos[43:40]) ? 16'hFFFF : w_kpos[39:24];

    // Restoring divider step.
    assign w_dsh   = {r_rem, r_dq[43]};
    assign w_ddiff = {1'b0, w_dsh} - {2'b00, r_ias, 10'h000};
    assign w_dge   = !w_ddiff[27];

    // Raw scale: clamp to the floor first, then to the ceiling.
    always_comb begin
        if (r_dq < {28'd0, r_scale_floor}) begin
            w_rawf = r_scale_floor;
        end else if (|r_dq[43:16]) begin
            w_rawf = r_scale_ceiling;
        end else begin
            w_rawf = r_dq[15:0];
        end
        if (w_rawf > r_scale_ceiling) begin
            w_rawf = r_scale_ceiling;
        end
    end
    assign w_raw = (r_phase == PH_DV) ? w_rawf : RAW_SCALE_ONE;
    assign w_sd  = $signed({8'h00, w_raw, 24'h000000}) - $signed({8'h00, r_fs});

    // Pitot scale filter update with clamping.
    assign w_fsn = $signed({2'b00, r_fs}) + w_prod[65:24];
    always_comb begin
        if (w_fsn[41]) begin
            w_fssat = '0;
        end else if (w_fsn[40]) begin
            w_fssat = {40{1'b1}};
        end else begin
            w_fssat = w_fsn[39:0];
        end
    end

    // Output saturation of the true air components.
    assign w_te_sat = (w_te[40] != w_te[39]) ? (w_te[40] ? 16'h8000 : 16'h7FFF) : w_te[39:24];
    assign w_tn_sat = (w_tn[40] != w_tn[39]) ? (w_tn[40] ? 16'h8000 : 16'h7FFF) : w_tn[39:24];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_airspeed  <= MIN_AIRSPEED_RST;
            r_wind_alpha    <= WIND_ALPHA_RST;
            r_scale_alpha   <= SCALE_ALPHA_RST;
            r_scale_floor   <= SCALE_FLOOR_RST;
            r_scale_ceiling <= SCALE_CEILING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_AIRSPEED:  r_min_airspeed  <= i_cfg_data[15:0];
                CFG_WIND_ALPHA:    r_wind_alpha    <= i_cfg_data;
                CFG_SCALE_ALPHA:   r_scale_alpha   <= i_cfg_data;
                CFG_SCALE_FLOOR:   r_scale_floor   <= i_cfg_data[15:0];
                CFG_SCALE_CEILING: r_scale_ceiling <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_U0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_fwe       <= '0;
            r_fwn       <= '0;
            r_fs        <= SCALE_ONE;
        end else begin
            // A new result is loaded, or the waiting one leaves.
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_indicated_airspeed >= r_min_airspeed)) begin
                        r_state <= ST_MUL;
                        r_phase <= PH_U0;
                        r_cnt   <= '0;
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(MUL_STEPS - 1)) begin
                        r_state <= ST_POST;
                    end
                end
                ST_CORD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                        r_state <= ST_POST;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    r_cnt <= '0;
                    unique case (r_phase)
                        PH_U0:  begin r_phase <= PH_U;   r_state <= ST_MUL;  end
                        PH_U:   begin r_phase <= PH_X0;  r_state <= ST_MUL;  end
                        PH_X0:  begin r_phase <= PH_ROT; r_state <= ST_CORD; end
                        PH_ROT: begin r_phase <= PH_WE;  r_state <= ST_MUL;  end
                        PH_WE: begin
                            r_fwe   <= w_wsat;
                            r_phase <= PH_WN;
                            r_state <= ST_MUL;
                        end
                        PH_WN: begin
                            r_fwn   <= w_wsat;
                            r_phase <= PH_VWS;
                        end
                        PH_VWS: begin
                            if (w_vzero) begin
                                r_phase <= PH_VTS;
                            end else begin
                                r_phase <= PH_VW;
                                r_state <= ST_CORD;
                            end
                        end
                        PH_VW:  begin r_phase <= PH_KW; r_state <= ST_MUL; end
                        PH_KW:  r_phase <= PH_VTS;
                        PH_VTS: begin
                            if (w_vzero) begin
                                r_phase <= PH_DVS;
                            end else begin
                                r_phase <= PH_VT;
                                r_state <= ST_CORD;
                            end
                        end
                        PH_VT:  begin r_phase <= PH_KT; r_state <= ST_MUL; end
                        PH_KT:  r_phase <= PH_DVS;
                        PH_DVS: begin
                            if (r_ias > ONE_KNOT) begin
                                r_phase <= PH_DV;
                                r_state <= ST_DIV;
                            end else begin
                                r_phase <= PH_SC;
                                r_state <= ST_MUL;
                            end
                        end
                        PH_DV:  begin r_phase <= PH_SC; r_state <= ST_MUL; end
                        PH_SC: begin
                            r_fs    <= w_fssat;
                            r_state <= ST_OUT;
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers of the serial units and intermediate results.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_ias  <= i_indicated_airspeed;
                    r_head <= i_heading_angle;
                    r_gve  <= i_ground_vel_east;
                    r_gvn  <= i_ground_vel_north;
                    r_ma   <= {22'd0, r_fs[39:14]};
                    r_mc   <= {14'd0, i_indicated_airspeed};
                    r_macc <= '0;
                    r_mlo  <= '0;
                end
            end
            ST_MUL: begin
                r_macc <= w_madd >>> 1;
                r_mlo  <= {w_madd[0], r_mlo[29:1]};
                r_mc   <= r_mc >> 1;
            end
            ST_CORD: begin
                if (w_cplus) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_tab;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_tab;
                end
            end
            ST_DIV: begin
                r_rem <= w_dge ? w_ddiff[25:0] : w_dsh[25:0];
                r_dq  <= {r_dq[42:0], w_dge};
            end
            ST_POST: begin
                r_macc <= '0;
                r_mlo  <= '0;
                case (r_phase)
                    // Scaled airspeed, then knots to m/s.
                    PH_U0: begin
                        r_ma <= {6'd0, w_prod[41:0]};
                        r_mc <= KT_TO_MPS_Q20;
                    end
                    // Pre-scale by the CORDIC gain.
                    PH_U: begin
                        r_ma <= {6'd0, w_prod[61:20]};
                        r_mc <= GAIN_Q30;
                    end
                    // Start the rotation along the heading.
                    PH_X0: begin
                        r_cx    <= w_flip ? -w_x0 : w_x0;
                        r_cy    <= '0;
                        r_cz    <= w_zf;
                        r_cmode <= 1'b0;
                    end
                    // Air vector ready: east innovation of the wind filter.
                    PH_ROT: begin
                        r_un <= r_cx;
                        r_ma <= {{3{r_cy[44]}}, r_cy} - w_ve48 - {{8{r_fwe[39]}}, r_fwe};
                        r_mc <= {6'd0, r_wind_alpha};
                    end
                    // North innovation of the wind filter.
                    PH_WE: begin
                        r_ma <= {{3{r_un[44]}}, r_un} - w_vn48 - {{8{r_fwn[39]}}, r_fwn};
                        r_mc <= {6'd0, r_wind_alpha};
                    end
                    // Start vectoring of the wind or true air vector.
                    PH_VWS, PH_VTS: begin
                        if (w_vzero) begin
                            if (r_phase == PH_VWS) begin
                                r_wdir <= ANGLE_EAST;
                                r_wspd <= '0;
                            end else begin
                                r_tdir <= ANGLE_EAST;
                                r_tspd <= '0;
                                r_tkt  <= '0;
                            end
                        end else begin
                            r_cx    <= w_vx_in[44] ? -w_vx_in : w_vx_in;
                            r_cy    <= w_vx_in[44] ? -w_vy_in : w_vy_in;
                            r_cz    <= w_vx_in[44] ? Z_HALF : 34'sd0;
                            r_cmode <= 1'b1;
                        end
                    end
                    // Vectoring done: keep the angle, convert the magnitude.
                    PH_VW, PH_VT: begin
                        if (r_phase == PH_VW) begin
                            r_wdir <= w_zr[31:16];
                        end else begin
                            r_tdir <= w_zr[31:16];
                        end
                        r_ma <= {{3{r_cx[44]}}, r_cx};
                        r_mc <= GAIN_MPS_TO_KT_Q20;
                    end
                    PH_KW: r_wspd <= w_spd;
                    PH_KT: begin
                        r_tspd <= w_spd;
                        r_tkt  <= w_kpos;
                    end
                    // Start the ratio divide, or take a raw scale of one.
                    PH_DVS: begin
                        r_dq  <= r_tkt;
                        r_rem <= '0;
                        r_ma  <= w_sd;
                        r_mc  <= {6'd0, r_scale_alpha};
                    end
                    PH_DV: begin
                        r_ma <= w_sd;
                        r_mc <= {6'd0, r_scale_alpha};
                    end
                    default: ;
                endcase
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_res.wind_speed         <= r_wspd;
                    r_res.wind_direction     <= r_wdir;
                    r_res.wind_east          <= r_fwe[39:24];
                    r_res.wind_north         <= r_fwn[39:24];
                    r_res.true_air_speed     <= r_tspd;
                    r_res.true_air_direction <= r_tdir;
                    r_res.true_air_east      <= w_te_sat;
                    r_res.true_air_north     <= w_tn_sat;
                    r_res.pitot_factor       <= r_fs[39:24];
                end
            end
            default: ;
        endcase
    end

endmodule

### bench/wpse_checker.sv
// Checker of the wind and pitot scale estimator: watches the configuration port and both
// request channels, predicts every result in fixed point and compares it field by field.
// Depends on wpse_pkg for the result record.
module wpse_checker import wpse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_indicated_airspeed,
    input  logic [15:0]        i_heading_angle,
    input  logic signed [15:0] i_ground_vel_east,
    input  logic signed [15:0] i_ground_vel_north,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_result            i_result,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int      ROT_STEPS    = 30;
    localparam longint  KT_MPS_Q20   = 539434;
    localparam longint  ROT_GAIN_Q30 = 652032874;
    localparam longint  GAIN_KT_Q20  = 1237745;
    localparam longint  INV_2PI_Q32  = 683565276;
    localparam longint  WIND_HI      = 64'sd549755813887;
    localparam longint  WIND_LO      = -64'sd549755813888;
    localparam longint  SCALE_HI     = 64'sd1099511627775;

    longint  atan_angle [ROT_STEPS];
    longint  wind_e_acc, wind_n_acc, scale_acc;
    logic [15:0] min_speed, floor_q14, ceiling_q14;
    logic [23:0] wind_gain, scale_gain;
    t_result pending_estimates [$];
    int      errors;

    assign o_errors  = errors;
    assign o_pending = pending_estimates.size();

    // Arctangent of 2^-i as a 32-bit binary angle, from its power series.
    initial begin
        longint s;
        longint unsigned term, q;
        int e;
        atan_angle[0] = 64'h2000_0000;
        for (int i = 1; i < ROT_STEPS; i++) begin
            s = 0;
            for (int k = 0; k < 64; k++) begin
                e = 60 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / longint'(2 * k + 1);
                    s = k[0] ? s - longint'(term) : s + longint'(term);
                end
            end
            q = (((longint'(s) + (64'sd1 << 27)) >> 28) * INV_2PI_Q32 + (64'd1 << 31)) >> 32;
            atan_angle[i] = longint'(q);
        end
    end

    // Product by a fraction c / 2^n, rounded toward minus infinity.
    function automatic longint mul_floor(longint v, longint c, int n);
        longint hi, lo;
        hi = v >>> n;
        lo = v - (hi <<< n);
        return hi * c + ((lo * c) >>> n);
    endfunction

    function automatic logic [15:0] clip_q88(longint q32);
        longint v;
        v = q32 >>> 24;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Turn a magnitude r through the angle a: cosine part and sine part.
    function automatic void turn_vector(longint r, longint unsigned a,
                                        output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = mul_floor(r, ROT_GAIN_Q30, 30);
        y = 0;
        z = longint'(a);
        if (z >= (64'sd1 <<< 31)) z -= 64'sd1 <<< 32;
        if (z > (64'sd1 <<< 30)) begin
            x = -x;
            z -= 64'sd1 <<< 31;
        end else if (z < -(64'sd1 <<< 30)) begin
            x = -x;
            z += 64'sd1 <<< 31;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_angle[i];
            end else begin
                x += dx; y -= dy; z += atan_angle[i];
            end
        end
        c = x;
        s = y;
    endfunction

    // Compass angle and speed of the vector (north n, east e).
    function automatic void polar_of(longint n, longint e, output logic [15:0] ang,
                                     output logic [15:0] spd, output longint kt);
        longint x, y, z, dx, dy, k;
        longint unsigned zu;
        if (n == 0 && e == 0) begin
            ang = 16'd16384; spd = 16'd0; kt = 0;
            return;
        end
        x = n; y = e; z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd1 <<< 31;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_angle[i];
            end else begin
                x -= dx; y += dy; z -= atan_angle[i];
            end
        end
        zu = ((longint'(z) & 64'hFFFF_FFFF) + 32768) >> 16;
        ang = zu[15:0];
        k = mul_floor(x, GAIN_KT_Q20, 20);
        if (k < 0) k = 0;
        kt = k;
        spd = ((k >>> 24) > 65535) ? 16'hFFFF : k[39:24];
    endfunction

    // One accepted sample: update the filters and give the result it causes.
    function automatic bit estimate_wind_and_scale(logic [15:0] ias, logic [15:0] hdg,
                                                   logic signed [15:0] ge,
                                                   logic signed [15:0] gn,
                                                   output t_result res);
        longint ve, vn, u, ue, un, te, tn, wkt, tkt, raw;
        logic [15:0] wang, wspd, tang, tspd;
        if (ias < min_speed) return 1'b0;
        ve = longint'(ge) <<< 24;
        vn = longint'(gn) <<< 24;
        u = longint'(ias) * (scale_acc >>> 14);
        u = mul_floor(u, KT_MPS_Q20, 20);
        turn_vector(u, 64'({hdg, 16'h0}), un, ue);
        wind_e_acc += mul_floor((ue - ve) - wind_e_acc, longint'(wind_gain), 24);
        wind_n_acc += mul_floor((un - vn) - wind_n_acc, longint'(wind_gain), 24);
        if (wind_e_acc > WIND_HI) wind_e_acc = WIND_HI;
        if (wind_e_acc < WIND_LO) wind_e_acc = WIND_LO;
        if (wind_n_acc > WIND_HI) wind_n_acc = WIND_HI;
        if (wind_n_acc < WIND_LO) wind_n_acc = WIND_LO;
        polar_of(wind_n_acc, wind_e_acc, wang, wspd, wkt);
        te = wind_e_acc + ve;
        tn = wind_n_acc + vn;
        polar_of(tn, te, tang, tspd, tkt);
        // Raw scale is one at or below one knot, else the clamped speed ratio.
        raw = 16384;
        if (ias > 16'd256) begin
            raw = longint'(longint'(unsigned'(tkt)) / (longint'(ias) <<< 10));
            if (raw < longint'(floor_q14)) raw = longint'(floor_q14);
            if (raw > longint'(ceiling_q14)) raw = longint'(ceiling_q14);
        end
        scale_acc += mul_floor((raw <<< 24) - scale_acc, longint'(scale_gain), 24);
        if (scale_acc < 0) scale_acc = 0;
        if (scale_acc > SCALE_HI) scale_acc = SCALE_HI;
        res.wind_speed         = wspd;
        res.wind_direction     = wang;
        res.wind_east          = clip_q88(wind_e_acc);
        res.wind_north         = clip_q88(wind_n_acc);
        res.true_air_speed     = tspd;
        res.true_air_direction = tang;
        res.true_air_east      = clip_q88(te);
        res.true_air_north     = clip_q88(tn);
        res.pitot_factor       = scale_acc[39:24];
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    initial errors = 0;

    // Track registers, predict on each input request, compare on each result request.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            min_speed   <= 16'd3840;
            wind_gain   <= 24'd3355;
            scale_gain  <= 24'd8389;
            floor_q14   <= 16'd12288;
            ceiling_q14 <= 16'd20480;
            wind_e_acc  = 0;
            wind_n_acc  = 0;
            scale_acc   = 64'sd1 <<< 38;
            pending_estimates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_AIRSPEED:  min_speed   <= i_cfg_data[15:0];
                    CFG_WIND_ALPHA:    wind_gain   <= i_cfg_data;
                    CFG_SCALE_ALPHA:   scale_gain  <= i_cfg_data;
                    CFG_SCALE_FLOOR:   floor_q14   <= i_cfg_data[15:0];
                    CFG_SCALE_CEILING: ceiling_q14 <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_estimates.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    errors++;
                end else begin
                    want = pending_estimates.pop_front();
                    check_field("wind_speed", i_result.wind_speed, want.wind_speed);
                    check_field("wind_direction", i_result.wind_direction,
                                want.wind_direction);
                    check_field("wind_east", i_result.wind_east, want.wind_east);
                    check_field("wind_north", i_result.wind_north, want.wind_north);
                    check_field("true_air_speed", i_result.true_air_speed,
                                want.true_air_speed);
                    check_field("true_air_direction", i_result.true_air_direction,
                                want.true_air_direction);
                    check_field("true_air_east", i_result.true_air_east,
                                want.true_air_east);
                    check_field("true_air_north", i_result.true_air_north,
                                want.true_air_north);
                    check_field("pitot_factor", i_result.pitot_factor, want.pitot_factor);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (estimate_wind_and_scale(i_indicated_airspeed, i_heading_angle,
                                            i_ground_vel_east, i_ground_vel_north, want))
                    pending_estimates.push_back(want);
            end
        end
    end

endmodule

### bench/wind_and_pitot_scale_estimator_top_tb.sv
// Testbench top of the wind and pitot scale estimator: clock, reset, register phases,
// directed and random samples, receiver stalls and the verdict.
// Depends on wpse_pkg, wind_and_pitot_scale_estimator_top and wpse_checker.
module wind_and_pitot_scale_estimator_top_tb import wpse_pkg::*;;

    localparam int SETTLE_CYCLES = 420;
    localparam int CYCLE_LIMIT   = 2000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [15:0]        i_indicated_airspeed = '0;
    logic [15:0]        i_heading_angle = '0;
    logic signed [15:0] i_ground_vel_east = '0;
    logic signed [15:0] i_ground_vel_north = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_result            dut_result;
    int                 mismatches, awaited, cycles;
    logic [15:0]        min_speed_now;
    bit                 sender_calm;

    wind_and_pitot_scale_estimator_top u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_ready,
        .i_indicated_airspeed, .i_heading_angle, .i_ground_vel_east, .i_ground_vel_north,
        .o_out_valid, .i_out_ready,
        .o_wind_speed         (dut_result.wind_speed),
        .o_wind_direction     (dut_result.wind_direction),
        .o_wind_east          (dut_result.wind_east),
        .o_wind_north         (dut_result.wind_north),
        .o_true_air_speed     (dut_result.true_air_speed),
        .o_true_air_direction (dut_result.true_air_direction),
        .o_true_air_east      (dut_result.true_air_east),
        .o_true_air_north     (dut_result.true_air_north),
        .o_pitot_factor       (dut_result.pitot_factor)
    );

    wpse_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready (o_in_ready),
        .i_indicated_airspeed, .i_heading_angle, .i_ground_vel_east, .i_ground_vel_north,
        .i_out_valid (o_out_valid), .i_out_ready,
        .i_result (dut_result), .o_errors (mismatches), .o_pending (awaited)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls per result, calm stretches, and one long hold-off.
    initial begin
        int taken, stall;
        bit calm;
        taken = 0;
        calm = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (taken % 30 == 0) calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, 18);
            if (taken == 60) stall = 3000;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // One register write per cycle; the caller drops the write enable at the end.
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_MIN_AIRSPEED) min_speed_now = val[15:0];
    endtask

    task automatic load_settings(logic [15:0] min_spd, logic [23:0] w_gain,
                                 logic [23:0] s_gain, logic [15:0] lo, logic [15:0] hi);
        write_reg(CFG_MIN_AIRSPEED, {8'd0, min_spd});
        write_reg(CFG_WIND_ALPHA, w_gain);
        write_reg(CFG_SCALE_ALPHA, s_gain);
        write_reg(CFG_SCALE_FLOOR, {8'd0, lo});
        write_reg(CFG_SCALE_CEILING, {8'd0, hi});
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample, after a random gap unless the sender is calm, and hold it until the request is taken.
    task automatic send_sample(logic [15:0] ias, logic [15:0] hdg,
                               logic [15:0] ge, logic [15:0] gn);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_indicated_airspeed <= ias;
        i_heading_angle      <= hdg;
        i_ground_vel_east    <= ge;
        i_ground_vel_north   <= gn;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Let every expected result drain, then let the block settle.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random samples, mostly fast enough to pass, some very slow or random.
    task automatic random_samples(int count);
        logic [15:0] ias;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0) sender_calm = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) ias = 16'($urandom_range(min_speed_now, 65535));
            else if (pick < 8) ias = 16'($urandom_range(0, 300));
            else ias = 16'($urandom());
            if ($urandom_range(0, 3) == 0)
                send_sample(ias, 16'($urandom()), 16'($urandom_range(0, 2000) - 1000),
                            16'($urandom_range(0, 2000) - 1000));
            else
                send_sample(ias, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
    endtask

    initial begin
        sender_calm = 1'b0;
        min_speed_now = 16'd3840;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples: zero vectors, slow samples, low airspeed, field extremes.
        load_settings(16'd0, 24'd3355, 24'd8389, 16'd12288, 16'd20480);
        send_sample(16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'd1, 16'd16384, 16'd0, 16'd0);
        send_sample(16'd256, 16'd32768, 16'd0, 16'd0);
        send_sample(16'd257, 16'd49152, 16'h7FFF, 16'h8000);
        send_sample(16'd65535, 16'd65535, 16'h8000, 16'h7FFF);
        send_sample(16'd65535, 16'd0, 16'h7FFF, 16'h7FFF);
        send_sample(16'd65535, 16'd32768, 16'h8000, 16'h8000);
        send_sample(16'd3840, 16'd8192, 16'hFFFF, 16'd1);
        drain_block();
        load_settings(16'd3840, 24'd3355, 24'd8389, 16'd12288, 16'd20480);
        send_sample(16'd3839, 16'd1000, 16'd5, 16'd5);
        send_sample(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'd3840, 16'd24576, 16'd300, 16'hFF00);
        send_sample(16'd65535, 16'd40960, 16'd0, 16'd0);
        random_samples(80);
        drain_block();

        // Fast filters with wide clamps: wind and scale saturation.
        load_settings(16'd0, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'hFFFF);
        send_sample(16'd65535, 16'd16384, 16'h8000, 16'h8000);
        send_sample(16'd65535, 16'd49152, 16'h7FFF, 16'h7FFF);
        random_samples(90);
        drain_block();

        // Slowest filters, floor above ceiling, only top airspeed passes.
        load_settings(16'hFFFF, 24'd1, 24'd1, 16'hFFFF, 16'd0);
        send_sample(16'd65534, 16'd0, 16'd0, 16'd0);
        random_samples(90);
        drain_block();

        // Random settings.
        for (int p = 0; p < 2; p++) begin
            load_settings(16'($urandom_range(0, 8000)), 24'($urandom_range(1, 24'hFFFFFF)),
                          24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom()),
                          16'($urandom()));
            random_samples(80);
            drain_block();
        end

        if (mismatches == 0 && awaited == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
design/wpse_pkg.sv
design/wind_and_pitot_scale_estimator_top.sv
bench/wpse_checker.sv
bench/wind_and_pitot_scale_estimator_top_tb.sv
